>>> rtl/rcs_pkg.sv
// Package of shared types, codes and constants for the integer core step block.
package rcs_pkg;

  localparam int unsigned QueueDepth = 8;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_INSN  = 3'd1,
    PH_LB    = 3'd2,
    PH_LH    = 3'd3,
    PH_LW    = 3'd4,
    PH_VEC   = 3'd5,
    PH_HALT  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    OPN_INSN = 2'd0,
    OPN_LOAD = 2'd1,
    OPN_VEC  = 2'd2,
    OPN_TICK = 2'd3
  } opn_t;

  localparam logic [3:0] KIND_FETCH = 4'd0;
  localparam logic [3:0] KIND_LB    = 4'd1;
  localparam logic [3:0] KIND_LH    = 4'd2;
  localparam logic [3:0] KIND_LW    = 4'd3;
  localparam logic [3:0] KIND_SB    = 4'd4;
  localparam logic [3:0] KIND_SH    = 4'd5;
  localparam logic [3:0] KIND_SW    = 4'd6;
  localparam logic [3:0] KIND_VEC   = 4'd7;
  localparam logic [3:0] KIND_WAIT  = 4'd8;

  localparam logic [0:0] CFG_IRQ_MASK = 1'd0;
  localparam logic [0:0] CFG_INIT_IE  = 1'd1;

  localparam logic [31:0] VECTOR_BASE = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] epc;
    logic [2:0]  cause;
    logic        z;
    logic        n;
    logic        ie;
    phase_t      phase;
    logic [4:0]  ltgt;
    logic        lsgn;
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  cyc;
    logic        last;
    logic [31:0] pc;
    logic        z;
    logic        n;
    logic        ie;
  } result_t;

  typedef struct packed {
    state_t      st;
    logic [1:0]  nres;
    result_t     r0;
    result_t     r1;
    logic        we;
    logic [4:0]  wa;
    logic [31:0] wd;
  } exec_out_t;

endpackage

>>> rtl/rcs_in_if.sv
// Input channel interface carrying bus replies and ticks.
interface rcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] reply_data;
  logic [7:0]  irq_pending;
  modport source (output valid, operation, reply_data, irq_pending, input ready);
  modport sink (input valid, operation, reply_data, irq_pending, output ready);
endinterface

>>> rtl/rcs_out_if.sv
// Result channel interface carrying bus requests and core status.
interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  request_kind;
  logic [31:0] request_address;
  logic [31:0] store_data;
  logic [2:0]  cycles_used;
  logic        last_of_run;
  logic [31:0] program_counter;
  logic        flag_zero;
  logic        flag_negative;
  logic        interrupts_enabled;
  modport source (output valid, request_kind, request_address, store_data, cycles_used,
                  last_of_run, program_counter, flag_zero, flag_negative,
                  interrupts_enabled, input ready);
  modport sink (input valid, request_kind, request_address, store_data, cycles_used,
                last_of_run, program_counter, flag_zero, flag_negative,
                interrupts_enabled, output ready);
endinterface

>>> rtl/rcs_cfg_if.sv
// Configuration write channel interface.
interface rcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/risc_integer_core_step_top.sv
// Top level of the integer core step block: input stage, register file and result queue.
// Each accepted transaction (instruction word, load datum, vector word or tick) is registered
// together with the two register file reads, executed in the following cycle, and its results
// (none, one or two) are written to a result queue at the end of that cycle. One transaction
// is accepted per clock while the result queue has room for the results of the transaction in
// flight and of the new one; an aligned store yields two results, so a run of stores is paced
// by the single result port at one result per cycle while out_ch is ready. The register file
// is held in two copies of a one-write, one-read RAM with registered read, so that rs and rt
// are read in the cycle of acceptance; entries never written read as zero through valid bits.
module risc_integer_core_step_top #(
  parameter int unsigned QUEUE_DEPTH = rcs_pkg::QueueDepth
) (
  input  logic   clk,
  input  logic   rst_n,
  rcs_in_if.sink    in_ch,
  rcs_out_if.source out_ch,
  rcs_cfg_if.sink   cfg_ch
);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH) + 1;

  rcs_pkg::state_t    st_r;
  rcs_pkg::exec_out_t eo;
  rcs_pkg::result_t   head;
  logic               s1_v_r;
  logic [1:0]         s1_op_r;
  logic [31:0]        s1_data_r;
  logic [7:0]         s1_pend_r;
  logic [7:0]         line_mask_r;
  logic               init_ie_r;
  logic [31:0]        regv_r;
  logic               va_r, vb_r, byp_a_r, byp_b_r;
  logic [31:0]        byp_d_r, ram_qa, ram_qb, opa, opb;
  logic [4:0]         rs_in, rt_in;
  logic [CW-1:0]      count;
  logic               accept, we;

  assign rs_in = in_ch.reply_data[25:21];
  assign rt_in = in_ch.reply_data[20:16];
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (CW+1)'(count) + (CW+1)'({s1_v_r, 1'b0})
                       <= (CW+1)'(QUEUE_DEPTH - 2);
  assign cfg_ch.ready = 1'b1;
  assign we = s1_v_r && eo.we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mask_r <= '0;
      init_ie_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rcs_pkg::CFG_IRQ_MASK: line_mask_r <= cfg_ch.data;
        rcs_pkg::CFG_INIT_IE:  init_ie_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  rcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(we), .waddr(eo.wa), .wdata(eo.wd), .raddr(rs_in), .rdata(ram_qa)
  );
  rcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(we), .waddr(eo.wa), .wdata(eo.wd), .raddr(rt_in), .rdata(ram_qb)
  );

  // A write landing in the same cycle as the read is forwarded past the RAM.
  always_ff @(posedge clk) begin
    s1_op_r <= in_ch.operation;
    s1_data_r <= in_ch.reply_data;
    s1_pend_r <= in_ch.irq_pending;
    va_r <= regv_r[rs_in];
    vb_r <= regv_r[rt_in];
    byp_a_r <= we && (eo.wa == rs_in);
    byp_b_r <= we && (eo.wa == rt_in);
    byp_d_r <= eo.wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      regv_r <= '0;
      st_r <= '{pc: '0, epc: '0, cause: '0, z: 1'b0, n: 1'b0, ie: 1'b0,
                phase: rcs_pkg::PH_START, ltgt: '0, lsgn: 1'b0};
    end else begin
      s1_v_r <= accept;
      if (we) begin
        regv_r[eo.wa] <= 1'b1;
      end
      if (s1_v_r) begin
        st_r <= eo.st;
      end
    end
  end

  assign opa = (s1_data_r[25:21] == 5'd0) ? 32'd0 :
               byp_a_r ? byp_d_r : (va_r ? ram_qa : 32'd0);
  assign opb = (s1_data_r[20:16] == 5'd0) ? 32'd0 :
               byp_b_r ? byp_d_r : (vb_r ? ram_qb : 32'd0);

  rcs_exec u_exec (
    .valid(s1_v_r), .operation(s1_op_r), .data(s1_data_r), .pending(s1_pend_r),
    .opa(opa), .opb(opb), .st(st_r), .line_mask(line_mask_r), .init_ie(init_ie_r),
    .eo(eo)
  );

  rcs_outq #(.DEPTH(QUEUE_DEPTH)) u_outq (
    .clk(clk), .rst_n(rst_n), .nres(s1_v_r ? eo.nres : 2'd0), .r0(eo.r0), .r1(eo.r1),
    .pop(out_ch.valid && out_ch.ready), .head(head), .count(count)
  );

  assign out_ch.valid = (count != '0);
  assign out_ch.request_kind = head.kind;
  assign out_ch.request_address = head.addr;
  assign out_ch.store_data = head.data;
  assign out_ch.cycles_used = head.cyc;
  assign out_ch.last_of_run = head.last;
  assign out_ch.program_counter = head.pc;
  assign out_ch.flag_zero = head.z;
  assign out_ch.flag_negative = head.n;
  assign out_ch.interrupts_enabled = head.ie;

  property p_r0_never_written;
    @(posedge clk) disable iff (!rst_n) !(we && eo.wa == 5'd0);
  endproperty
  a_r0_never_written: assert property (p_r0_never_written) else $error("write to r0");

  property p_accept_reaches_stage;
    @(posedge clk) disable iff (!rst_n) accept |=> s1_v_r;
  endproperty
  a_accept_reaches_stage: assert property (p_accept_reaches_stage)
    else $error("accepted transaction lost before execute");

  property p_idle_keeps_state;
    @(posedge clk) disable iff (!rst_n) !s1_v_r |=> $stable(st_r);
  endproperty
  a_idle_keeps_state: assert property (p_idle_keeps_state)
    else $error("state changed without a transaction");
endmodule

>>> rtl/rcs_ram.sv
// Generic single write port RAM with one registered read port.
module rcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/rcs_exec.sv
// Decode and execute of one reply against the architectural state.
module rcs_exec (
  input  logic                  valid,
  input  logic [1:0]            operation,
  input  logic [31:0]           data,
  input  logic [7:0]            pending,
  input  logic [31:0]           opa,
  input  logic [31:0]           opb,
  input  rcs_pkg::state_t       st,
  input  logic [7:0]            line_mask,
  input  logic                  init_ie,
  output rcs_pkg::exec_out_t    eo
);
  typedef enum logic [1:0] {FM_NONE, FM_NEXT, FM_HALT, FM_LOAD} fin_t;

  always_comb begin
    rcs_pkg::state_t  ns;
    rcs_pkg::result_t pre, fin;
    logic        pre_v, take, bad, irq_take;
    fin_t        fm;
    logic [2:0]  cyc, line;
    logic [7:0]  live;
    logic [5:0]  opc, fn;
    logic [4:0]  rt, rd, sh;
    logic [31:0] imm, simm, addr, pcn, boff, v, ld;
    logic [3:0]  lkind;

    ns = st;
    pre = '0;
    fin = '0;
    pre_v = 1'b0;
    take = 1'b0;
    bad = 1'b0;
    fm = FM_NONE;
    cyc = 3'd0;
    lkind = rcs_pkg::KIND_LB;
    eo.we = 1'b0;
    eo.wa = '0;
    eo.wd = '0;
    opc = data[31:26];
    rt = data[20:16];
    rd = data[15:11];
    sh = data[10:6];
    fn = data[5:0];
    imm = {16'd0, data[15:0]};
    simm = {{16{data[15]}}, data[15:0]};
    addr = opa + simm;
    pcn = st.pc + 32'd4;
    boff = st.pc + 32'd4 + {simm[29:0], 2'b00};
    v = '0;
    ld = '0;

    if (valid) begin
      if (st.phase == rcs_pkg::PH_START && operation == rcs_pkg::OPN_TICK) begin
        ns.ie = init_ie;
        fm = FM_NEXT;
      end else if (st.phase == rcs_pkg::PH_HALT && operation == rcs_pkg::OPN_TICK) begin
        fm = FM_HALT;
      end else if (st.phase == rcs_pkg::PH_VEC && operation == rcs_pkg::OPN_VEC) begin
        ns.pc = data;
        fm = FM_NEXT;
        cyc = 3'd4;
      end else if ((st.phase == rcs_pkg::PH_LB || st.phase == rcs_pkg::PH_LH ||
                    st.phase == rcs_pkg::PH_LW) && operation == rcs_pkg::OPN_LOAD) begin
        if (st.phase == rcs_pkg::PH_LB) begin
          ld = {{24{st.lsgn & data[7]}}, data[7:0]};
        end else if (st.phase == rcs_pkg::PH_LH) begin
          ld = {{16{st.lsgn & data[15]}}, data[15:0]};
        end else begin
          ld = data;
        end
        eo.we = (st.ltgt != 5'd0);
        eo.wa = st.ltgt;
        eo.wd = ld;
        fm = FM_NEXT;
      end else if (st.phase == rcs_pkg::PH_INSN && operation == rcs_pkg::OPN_INSN) begin
        cyc = 3'd1;
        fm = FM_NEXT;
        eo.wa = rt;
        unique case (opc)
          6'h00: begin
            eo.wa = rd;
            eo.we = 1'b1;
            unique case (fn)
              6'h00: v = opb << sh;
              6'h02: v = opb >> sh;
              6'h03: v = $unsigned($signed(opb) >>> sh);
              6'h04: v = opb << opa[4:0];
              6'h06: v = opb >> opa[4:0];
              6'h07: v = $unsigned($signed(opb) >>> opa[4:0]);
              6'h08: begin
                eo.we = 1'b0;
                pcn = opa;
                cyc = 3'd2;
              end
              6'h09: begin
                v = st.pc + 32'd4;
                pcn = opa;
                cyc = 3'd2;
              end
              6'h20, 6'h21: v = opa + opb;
              6'h22, 6'h23: v = opa - opb;
              6'h24: v = opa & opb;
              6'h25: v = opa | opb;
              6'h26: v = opa ^ opb;
              6'h27: v = ~(opa | opb);
              6'h2A: v = {31'd0, $signed(opa) < $signed(opb)};
              6'h2B: v = {31'd0, opa < opb};
              default: eo.we = 1'b0;
            endcase
            if (fn >= 6'h20 && fn <= 6'h27) begin
              ns.z = (v == 32'd0);
              ns.n = v[31];
            end
          end
          6'h02, 6'h03: begin
            eo.we = opc[0];
            eo.wa = 5'd31;
            v = st.pc + 32'd4;
            pcn = {st.pc[31:28], data[25:0], 2'b00};
            cyc = 3'd2;
          end
          6'h08, 6'h09, 6'h0C, 6'h0D, 6'h0E: begin
            eo.we = 1'b1;
            priority case (opc)
              6'h0C:   v = opa & imm;
              6'h0D:   v = opa | imm;
              6'h0E:   v = opa ^ imm;
              default: v = addr;
            endcase
            ns.z = (v == 32'd0);
            ns.n = v[31];
          end
          6'h0A: begin
            eo.we = 1'b1;
            v = {31'd0, $signed(opa) < $signed(simm)};
          end
          6'h0B: begin
            eo.we = 1'b1;
            v = {31'd0, opa < simm};
          end
          6'h0F: begin
            eo.we = 1'b1;
            v = {data[15:0], 16'd0};
          end
          6'h04: take = (opa == opb);
          6'h05: take = (opa != opb);
          6'h14: take = $signed(opa) < $signed(opb);
          6'h15: take = $signed(opb) < $signed(opa);
          6'h16: take = !($signed(opb) < $signed(opa));
          6'h17: take = !($signed(opa) < $signed(opb));
          6'h20, 6'h21, 6'h23, 6'h24, 6'h25: begin
            priority if (opc == 6'h23) begin
              lkind = rcs_pkg::KIND_LW;
              bad = (addr[1:0] != 2'd0);
            end else if (opc[0]) begin
              lkind = rcs_pkg::KIND_LH;
              bad = addr[0];
            end else begin
              lkind = rcs_pkg::KIND_LB;
            end
            cyc = 3'd3;
            if (bad) begin
              eo.we = 1'b1;
              v = '0;
            end else begin
              fm = FM_LOAD;
              ns.ltgt = rt;
              ns.lsgn = (opc < 6'h24);
              priority if (lkind == rcs_pkg::KIND_LB) ns.phase = rcs_pkg::PH_LB;
              else if (lkind == rcs_pkg::KIND_LH) ns.phase = rcs_pkg::PH_LH;
              else ns.phase = rcs_pkg::PH_LW;
            end
          end
          6'h28, 6'h29, 6'h2B: begin
            cyc = 3'd3;
            pre.addr = addr;
            priority if (opc == 6'h28) begin
              pre_v = 1'b1;
              pre.kind = rcs_pkg::KIND_SB;
              pre.data = {24'd0, opb[7:0]};
            end else if (opc == 6'h29) begin
              pre_v = !addr[0];
              pre.kind = rcs_pkg::KIND_SH;
              pre.data = {16'd0, opb[15:0]};
            end else begin
              pre_v = (addr[1:0] == 2'd0);
              pre.kind = rcs_pkg::KIND_SW;
              pre.data = opb;
            end
            pre.cyc = 3'd3;
            if (pre_v) begin
              cyc = 3'd0;
            end
          end
          6'h3F: begin
            priority if (fn == 6'h04) begin
              pcn = st.epc;
              ns.ie = 1'b1;
              cyc = 3'd2;
            end else if (fn == 6'h03) begin
              // HALT keeps pc on the HALT word.
              pcn = st.pc;
              fm = FM_HALT;
            end else if (fn == 6'h00) begin
              cyc = 3'd4;
            end else begin
              cyc = 3'd1;
            end
          end
          default: ;
        endcase
        eo.we = eo.we && (eo.wa != 5'd0);
        eo.wd = v;
        if (take) begin
          pcn = boff;
          cyc = 3'd2;
        end
        ns.pc = pcn;
      end
    end

    // Highest unmasked pending line wins.
    live = pending & ~line_mask;
    line = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (live[i]) begin
        line = 3'(i);
      end
    end
    irq_take = ns.ie && (live != 8'd0);

    unique case (fm)
      FM_NEXT, FM_HALT: begin
        if (irq_take) begin
          ns.epc = ns.pc;
          ns.cause = line;
          ns.ie = 1'b0;
          ns.phase = rcs_pkg::PH_VEC;
          fin.kind = rcs_pkg::KIND_VEC;
          fin.addr = rcs_pkg::VECTOR_BASE + {27'd0, line, 2'b00};
          fin.cyc = (fm == FM_HALT) ? 3'd0 : cyc;
        end else if (fm == FM_HALT) begin
          ns.phase = rcs_pkg::PH_HALT;
          fin.kind = rcs_pkg::KIND_WAIT;
          fin.cyc = 3'd1;
        end else begin
          ns.phase = rcs_pkg::PH_INSN;
          fin.kind = rcs_pkg::KIND_FETCH;
          fin.addr = ns.pc;
          fin.cyc = cyc;
        end
      end
      FM_LOAD: begin
        fin.kind = lkind;
        fin.addr = addr;
        fin.cyc = cyc;
      end
      default: ;
    endcase

    pre.pc = ns.pc;
    pre.z = ns.z;
    pre.n = ns.n;
    pre.ie = ns.ie;
    fin.pc = ns.pc;
    fin.z = ns.z;
    fin.n = ns.n;
    fin.ie = ns.ie;
    fin.last = 1'b1;

    eo.st = ns;
    eo.r1 = fin;
    if (fm == FM_NONE) begin
      eo.nres = 2'd0;
      eo.r0 = fin;
    end else if (pre_v) begin
      eo.nres = 2'd2;
      eo.r0 = pre;
    end else begin
      eo.nres = 2'd1;
      eo.r0 = fin;
    end
  end
endmodule

>>> rtl/rcs_outq.sv
// Result queue that takes up to two results a cycle and delivers one a cycle while popped.
module rcs_outq #(
  parameter int unsigned DEPTH = rcs_pkg::QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               nres,
  input  rcs_pkg::result_t         r0,
  input  rcs_pkg::result_t         r1,
  input  logic                     pop,
  output rcs_pkg::result_t         head,
  output logic [$clog2(DEPTH):0]   count
);
  localparam int unsigned PW = $clog2(DEPTH);

  rcs_pkg::result_t  q_r [DEPTH];
  logic [PW-1:0]     wptr_r, rptr_r;
  logic [PW:0]       cnt_r;

  assign head = q_r[rptr_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      q_r[wptr_r] <= r0;
    end
    if (nres == 2'd2) begin
      q_r[wptr_r + PW'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_r + PW'(nres);
      rptr_r <= rptr_r + PW'(pop);
      cnt_r <= cnt_r + (PW+1)'(nres) - (PW+1)'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) cnt_r <= (PW+1)'(DEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("result queue overflow");

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) pop |-> cnt_r != '0;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("result queue underflow");

  property p_two_need_store;
    @(posedge clk) disable iff (!rst_n)
      nres == 2'd2 |-> (r0.kind == rcs_pkg::KIND_SB || r0.kind == rcs_pkg::KIND_SH ||
                        r0.kind == rcs_pkg::KIND_SW) && !r0.last && r1.last;
  endproperty
  a_two_need_store: assert property (p_two_need_store)
    else $error("two results without a leading store");
endmodule
